/* hw/rtl/ladsq_pkg.sv */
package ladsq_pkg;

  localparam int unsigned ElemW    = 8;
  localparam int unsigned MaskW    = 10;
  localparam int unsigned DimW     = 9;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CoordW   = 8;
  localparam int unsigned SideW    = 9;
  localparam int unsigned MaxDigit = 9;
  localparam int unsigned MinSide  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIGIT_MASK = 2'd0,
    CFG_NUM_ROWS   = 2'd1,
    CFG_NUM_COLS   = 2'd2
  } cfg_idx_e;

  localparam logic [MaskW-1:0] MaskReset = '0;
  localparam logic [DimW-1:0]  DimReset  = 9'd256;

endpackage

/* hw/rtl/ladsq_elem_if.sv */
interface ladsq_elem_if;
  logic                           valid;
  logic                           ready;
  logic [ladsq_pkg::ElemW-1:0]    element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

/* hw/rtl/ladsq_res_if.sv */
interface ladsq_res_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [ladsq_pkg::CoordW-1:0]   top_row;
  logic [ladsq_pkg::CoordW-1:0]   left_col;
  logic [ladsq_pkg::SideW-1:0]    side;

  modport source (output valid, output found, output top_row, output left_col,
                  output side, input ready);
  modport sink   (input valid, input found, input top_row, input left_col,
                  input side, output ready);
endinterface

/* hw/rtl/ladsq_ram.sv */
module ladsq_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/largest_allowed_digit_square.sv */
// The result for the last element of a matrix is loaded from the element register
// into the result register, and waits while the result channel holds an untaken result.
// Throughput: one element per cycle but for that wait; the line buffer RAM is read
// on accept and a same-column write is forwarded when the matrix is one column wide.
// Reset: rst_ni clears the position, the best square and the handshake state,
// and sets the mask to 0 and both dimensions to 256; the line buffer is not cleared.
module largest_allowed_digit_square #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ladsq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ladsq_pkg::CfgDataW-1:0]     cfg_data_i,
  ladsq_elem_if.sink                         elem_i,
  ladsq_res_if.source                        res_o
);

  localparam int unsigned CW   = $clog2(MAX_COLS);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned MaxD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned SW   = $clog2(MaxD + 1);

  // configuration
  logic [ladsq_pkg::MaskW-1:0] mask_q;
  logic [ladsq_pkg::DimW-1:0]  rows_cfg_q, cols_cfg_q;
  logic                        restart;
  logic [CW:0]                 cols_eff;
  logic [RW:0]                 rows_eff;

  assign restart = cfg_we_i && ((cfg_idx_i == ladsq_pkg::CFG_NUM_ROWS) ||
                                (cfg_idx_i == ladsq_pkg::CFG_NUM_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= ladsq_pkg::MaskReset;
      rows_cfg_q <= ladsq_pkg::DimReset;
      cols_cfg_q <= ladsq_pkg::DimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ladsq_pkg::CFG_DIGIT_MASK: mask_q     <= cfg_data_i[ladsq_pkg::MaskW-1:0];
        ladsq_pkg::CFG_NUM_ROWS:   rows_cfg_q <= cfg_data_i[ladsq_pkg::DimW-1:0];
        ladsq_pkg::CFG_NUM_COLS:   cols_cfg_q <= cfg_data_i[ladsq_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_eff = (CW+1)'(1);
    end else if (32'(cols_cfg_q) > MAX_COLS) begin
      cols_eff = (CW+1)'(MAX_COLS);
    end else begin
      cols_eff = (CW+1)'(cols_cfg_q);
    end
    if (rows_cfg_q == '0) begin
      rows_eff = (RW+1)'(1);
    end else if (32'(rows_cfg_q) > MAX_ROWS) begin
      rows_eff = (RW+1)'(MAX_ROWS);
    end else begin
      rows_eff = (RW+1)'(rows_cfg_q);
    end
  end

  // handshake
  logic s1_valid_q, s1_last_q, s1_done, out_free, elem_acc;
  logic out_valid_q;

  assign out_free     = !out_valid_q || res_o.ready;
  assign s1_done      = s1_valid_q && (!s1_last_q || out_free);
  assign elem_i.ready = !s1_valid_q || s1_done;
  assign elem_acc     = elem_i.valid && elem_i.ready;

  // position at the accept side
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          last_col, last_row;

  assign last_col = ({1'b0, col_q} + (CW+1)'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_q} + (RW+1)'(1)) >= rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (elem_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // element register
  logic [ladsq_pkg::ElemW-1:0] s1_val_q;
  logic [CW-1:0]               s1_col_q;
  logic [RW-1:0]               s1_row_q;
  logic                        byp_q;
  logic [SW-1:0]               fwd_q;
  logic [SW-1:0]               size;
  logic [SW-1:0]               up_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      byp_q      <= 1'b0;
    end else if (elem_i.ready) begin
      s1_valid_q <= elem_i.valid;
      s1_last_q  <= last_col && last_row;
      byp_q      <= s1_done && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_acc) begin
      s1_val_q <= elem_i.element_value;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      fwd_q    <= size;
    end
  end

  ladsq_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_done),
    .waddr_i (s1_col_q),
    .wdata_i (size),
    .re_i    (elem_acc),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  // recurrence
  logic [SW-1:0] left_q, diag_q, up, left, diag, m3;
  logic [SW-1:0] best_side_q, best_side_d;
  logic [RW-1:0] best_row_q, best_row_d;
  logic [CW-1:0] best_col_q, best_col_d;
  logic          qual;
  logic [SW:0]   row_tl, col_tl;

  always_comb begin
    qual = (32'(s1_val_q) <= ladsq_pkg::MaxDigit) &&
           mask_q[s1_val_q[$clog2(ladsq_pkg::MaskW)-1:0]];
    up   = (s1_row_q != '0) ? (byp_q ? fwd_q : up_rd) : '0;
    left = (s1_col_q != '0) ? left_q : '0;
    diag = ((s1_col_q != '0) && (s1_row_q != '0)) ? diag_q : '0;
    m3   = (up < left) ? up : left;
    m3   = (m3 < diag) ? m3 : diag;
    size = qual ? m3 + SW'(1) : '0;

    row_tl = (SW+1)'(s1_row_q) + (SW+1)'(1) - (SW+1)'(size);
    col_tl = (SW+1)'(s1_col_q) + (SW+1)'(1) - (SW+1)'(size);

    best_side_d = best_side_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    if ((32'(size) >= ladsq_pkg::MinSide) && (size > best_side_q)) begin
      best_side_d = size;
      best_row_d  = RW'(row_tl);
      best_col_d  = CW'(col_tl);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_side_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (restart) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_side_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (s1_done) begin
      left_q <= size;
      diag_q <= up;
      if (s1_last_q) begin
        best_side_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        best_side_q <= best_side_d;
        best_row_q  <= best_row_d;
        best_col_q  <= best_col_d;
      end
    end
  end

  // result register
  logic                         found_d;
  logic                         found_q;
  logic [ladsq_pkg::CoordW-1:0] top_row_q, left_col_q;
  logic [ladsq_pkg::SideW-1:0]  side_q;

  assign found_d = 32'(best_side_d) >= ladsq_pkg::MinSide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_done && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && s1_last_q) begin
      found_q    <= found_d;
      top_row_q  <= found_d ? ladsq_pkg::CoordW'(best_row_d) : '0;
      left_col_q <= found_d ? ladsq_pkg::CoordW'(best_col_d) : '0;
      side_q     <= found_d ? ladsq_pkg::SideW'(best_side_d) : '0;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.found    = found_q;
  assign res_o.top_row  = top_row_q;
  assign res_o.left_col = left_col_q;
  assign res_o.side     = side_q;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < cols_eff))
    else $error("column position beyond configured width");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && s1_last_q) |=> res_o.valid)
    else $error("last element did not load a result");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.found) |->
      (res_o.side == '0 && res_o.top_row == '0 && res_o.left_col == '0))
    else $error("empty result carries a nonzero square");

endmodule
